// ----- hw/rtl/planar_odometry_integrator_core_assert.svh -----
// Assertion macros for the odometry integrator core
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define POI_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define POI_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define POI_ASSERT_IMP(label, clk, rst_n, a, c)
`define POI_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/poi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_pkg
// Shared types and constants of the odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;
    localparam int CordicStages = 16;
    localparam int CntW = 6;
    localparam logic [0:0] OP_CMD  = 1'b0;
    localparam logic [0:0] OP_TICK = 1'b1;
    localparam logic [0:0] REG_GAIN = 1'b0;
    localparam logic [0:0] REG_DT   = 1'b1;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [33:0] K_Q30 = 34'sd652032874;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    typedef struct packed {
        logic [0:0]         op;
        logic signed [15:0] target_linear;
        logic signed [15:0] target_angular;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] lin_speed;
        logic signed [15:0] ang_speed;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SMOOTH, ST_CORDIC, ST_MULX, ST_MULY, ST_HEAD, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        unique case (i)
            5'd0:  atan_q30 = 34'sd843314857;
            5'd1:  atan_q30 = 34'sd497837829;
            5'd2:  atan_q30 = 34'sd263043837;
            5'd3:  atan_q30 = 34'sd133525159;
            5'd4:  atan_q30 = 34'sd67021687;
            5'd5:  atan_q30 = 34'sd33543516;
            5'd6:  atan_q30 = 34'sd16775851;
            5'd7:  atan_q30 = 34'sd8388437;
            5'd8:  atan_q30 = 34'sd4194283;
            5'd9:  atan_q30 = 34'sd2097149;
            5'd10: atan_q30 = 34'sd1048576;
            5'd11: atan_q30 = 34'sd524288;
            5'd12: atan_q30 = 34'sd262144;
            5'd13: atan_q30 = 34'sd131072;
            5'd14: atan_q30 = 34'sd65536;
            5'd15: atan_q30 = 34'sd32768;
            5'd16: atan_q30 = 34'sd16384;
            5'd17: atan_q30 = 34'sd8192;
            5'd18: atan_q30 = 34'sd4096;
            5'd19: atan_q30 = 34'sd2048;
            5'd20: atan_q30 = 34'sd1024;
            5'd21: atan_q30 = 34'sd512;
            5'd22: atan_q30 = 34'sd256;
            5'd23: atan_q30 = 34'sd128;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction
endpackage

// ----- hw/rtl/poi_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_if
// Valid/ready channel carrying one item per beat.
// ----------------------------------------------------------------------------
interface poi_in_if import poi_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface poi_out_if import poi_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/planar_odometry_integrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_core
// Dead-reckoning pose integrator with speed smoothing and CORDIC heading.
// ----------------------------------------------------------------------------
// Command beats are absorbed without a result; a tick runs seven serial multiplies
// (two smoothing, two per axis, one heading) and a CORDIC rotation, then loads
// the result register, which waits while an unread result is held; the next
// tick is taken once the core is back in idle.
// Reset clears pose, speeds and goals to zero, gain to 6554 and step to 655.
`include "planar_odometry_integrator_core_assert.svh"
module planar_odometry_integrator_core import poi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    poi_in_if.sink      in_ch,
    poi_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    state_t state_reg, state_next;
    logic [15:0] gain_reg, dt_reg;
    logic signed [15:0] goal_lin_reg, goal_ang_reg, cur_lin_reg, cur_ang_reg, yaw_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [1:0] sub_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    unit_ctl_t mul_ctl, cor_ctl;
    logic signed [33:0] mcand, mplier;
    logic mul_done, cor_done;
    logic signed [67:0] product;
    logic signed [33:0] cos_w, sin_w;

    poi_serial_mul u_mul (.clk, .rst_n, .ctl_in(mul_ctl), .mcand, .mplier,
                          .done(mul_done), .product);
    poi_cordic u_cordic (.clk, .rst_n, .ctl_in(cor_ctl), .angle(yaw_reg),
                         .done(cor_done), .cos_out(cos_w), .sin_out(sin_w));

    logic accept;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;

    // rounding helpers
    logic signed [67:0] rnd16, rnd42, rnd15;
    logic signed [16:0] dsum;
    logic signed [33:0] psum;
    logic signed [17:0] hsum;
    logic signed [17:0] hwrap;
    logic signed [15:0] sm_val;
    logic signed [31:0] ps_val;
    logic signed [15:0] hd_val;
    assign rnd16 = (product + 68'sd32768) >>> 16;
    assign rnd42 = (product + (68'sd1 <<< 41)) >>> 42;
    assign rnd15 = (product + 68'sd16384) >>> 15;
    logic signed [15:0] cur_sel;
    assign cur_sel = sub_reg[1] ? cur_ang_reg : cur_lin_reg;
    assign dsum = 17'(cur_sel) + 17'(rnd16);
    assign sm_val = (dsum > 17'sd32767) ? 16'sh7fff :
                    (dsum < -17'sd32768) ? 16'sh8000 : dsum[15:0];
    logic signed [31:0] p_sel;
    assign p_sel = (state_reg == ST_MULY) ? py_reg : px_reg;
    assign psum = 34'(p_sel) + 34'(rnd42);
    assign ps_val = (psum > 34'sd2147483647) ? 32'sh7fffffff :
                    (psum < -34'sd2147483648) ? 32'sh80000000 : psum[31:0];
    assign hsum = 18'(yaw_reg) + 18'(rnd15);

    // fold the heading back into [-pi, pi]; a full step may need two folds
    always_comb
    begin
        hwrap = hsum;
        if (hwrap > 18'(PI_Q13))
            hwrap = hwrap - TWO_PI_Q13;
        else if (hwrap < -18'(PI_Q13))
            hwrap = hwrap + TWO_PI_Q13;
        if (hwrap > 18'(PI_Q13))
            hwrap = hwrap - TWO_PI_Q13;
        else if (hwrap < -18'(PI_Q13))
            hwrap = hwrap + TWO_PI_Q13;
        hd_val = hwrap[15:0];
    end

    // multiplier operands per phase; sub_reg[1] picks the second multiply
    logic signed [33:0] trig_sel;
    assign trig_sel = (state_reg == ST_MULY) ? sin_reg : cos_reg;
    always_comb
    begin
        mcand  = '0;
        mplier = '0;
        unique case (state_reg)
            ST_SMOOTH:
            begin
                mcand  = 34'({1'b0, gain_reg});
                mplier = sub_reg[1] ? 34'(goal_ang_reg) - 34'(cur_ang_reg)
                                    : 34'(goal_lin_reg) - 34'(cur_lin_reg);
            end
            ST_MULX, ST_MULY:
            begin
                mcand  = sub_reg[1] ? 34'(product[33:0]) : 34'(cur_lin_reg);
                mplier = sub_reg[1] ? trig_sel : 34'({1'b0, dt_reg});
            end
            ST_HEAD:
            begin
                mcand  = 34'(cur_ang_reg);
                mplier = 34'({1'b0, dt_reg});
            end
            default: ;
        endcase
    end

    // next state: start a multiply on even sub steps, wait for it on odd ones
    logic mul_go, cor_go, out_load;
    always_comb
    begin
        state_next = state_reg;
        mul_go = 1'b0;
        cor_go = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_ch.data.op == OP_TICK)
                    state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                mul_go = !sub_reg[0];
                if (sub_reg == 2'd3 && mul_done)
                begin
                    state_next = ST_CORDIC;
                    cor_go = 1'b1;
                end
            end
            ST_CORDIC:
            begin
                if (cor_done)
                    state_next = ST_MULX;
            end
            ST_MULX:
            begin
                mul_go = !sub_reg[0];
                if (sub_reg == 2'd3 && mul_done)
                    state_next = ST_MULY;
            end
            ST_MULY:
            begin
                mul_go = !sub_reg[0];
                if (sub_reg == 2'd3 && mul_done)
                    state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                mul_go = !sub_reg[0];
                if (sub_reg == 2'd1 && mul_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
    assign mul_ctl = '{start: mul_go, busy: state_reg != ST_IDLE};
    assign cor_ctl = '{start: cor_go, busy: state_reg == ST_CORDIC};

    // sequence control: sub_reg counts start/wait steps within each phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sub_reg <= '0;
            gain_reg <= 16'd6554;
            dt_reg <= 16'd655;
            goal_lin_reg <= '0;
            goal_ang_reg <= '0;
            cur_lin_reg <= '0;
            cur_ang_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            yaw_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_GAIN)
                    gain_reg <= cfg_data;
                else
                    dt_reg <= cfg_data;
            end
            if (accept && in_ch.data.op == OP_CMD)
            begin
                goal_lin_reg <= in_ch.data.target_linear;
                goal_ang_reg <= in_ch.data.target_angular;
            end
            if (state_next != state_reg)
                sub_reg <= '0;
            else if (mul_go || (sub_reg[0] && mul_done))
                sub_reg <= sub_reg + 2'd1;
            if (state_reg == ST_SMOOTH && mul_done)
            begin
                if (sub_reg[1])
                    cur_ang_reg <= sm_val;
                else
                    cur_lin_reg <= sm_val;
            end
            if (sub_reg == 2'd3 && mul_done)
            begin
                if (state_reg == ST_MULX)
                    px_reg <= ps_val;
                else if (state_reg == ST_MULY)
                    py_reg <= ps_val;
            end
            if (state_reg == ST_HEAD && mul_done)
                yaw_reg <= hd_val;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // capture CORDIC results and load the output register
    always_ff @(posedge clk)
    begin
        if (cor_done)
        begin
            cos_reg <= cos_w;
            sin_reg <= sin_w;
        end
        if (out_load)
        begin
            out_reg.pos_x <= px_reg;
            out_reg.pos_y <= py_reg;
            out_reg.heading <= yaw_reg;
            out_reg.lin_speed <= cur_lin_reg;
            out_reg.ang_speed <= cur_ang_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    `POI_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == ST_IDLE)
    `POI_ASSERT_IMP(a_head_range, clk, rst_n, out_ch.valid,
        out_ch.data.heading <= PI_Q13 && out_ch.data.heading >= -PI_Q13)
    `POI_ASSERT_NXT(a_cmd_no_out, clk, rst_n,
        accept && in_ch.data.op == OP_CMD && !out_valid_reg, !out_ch.valid)
endmodule

// ----- hw/rtl/poi_serial_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_serial_mul
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module poi_serial_mul import poi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  unit_ctl_t          ctl_in,
    input  logic signed [33:0] mcand,
    input  logic signed [33:0] mplier,
    output logic               done,
    output logic signed [67:0] product
);
    logic signed [67:0] acc_reg;
    logic signed [67:0] mc_reg;
    logic [33:0]        mp_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               run_reg;
    logic               done_reg;

    // step one multiplier bit per cycle; top bit carries negative weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CntW'(1);
                if (cnt_reg == CntW'(33))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            acc_reg <= '0;
            mc_reg  <= 68'(mcand);
            mp_reg  <= mplier;
        end
        else if (run_reg)
        begin
            if (mp_reg[0])
            begin
                if (cnt_reg == CntW'(33))
                    acc_reg <= acc_reg - mc_reg;
                else
                    acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg <<< 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// ----- hw/rtl/poi_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module poi_cordic import poi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  unit_ctl_t          ctl_in,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic [4:0]         i_reg;
    logic               run_reg;
    logic               done_reg;
    logic signed [33:0] z0;

    assign z0 = 34'(angle) <<< 17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(CordicStages - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // fold into the right half plane, then rotate one stage per cycle
    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            x_reg <= K_Q30;
            y_reg <= '0;
            if (z0 > HALF_PI_Q30)
            begin
                z_reg    <= z0 - PI_Q30;
                flip_reg <= 1'b1;
            end
            else if (z0 < -HALF_PI_Q30)
            begin
                z_reg    <= z0 + PI_Q30;
                flip_reg <= 1'b1;
            end
            else
            begin
                z_reg    <= z0;
                flip_reg <= 1'b0;
            end
        end
        else if (run_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - (y_reg >>> i_reg);
                y_reg <= y_reg + (x_reg >>> i_reg);
                z_reg <= z_reg - atan_q30(i_reg);
            end
            else
            begin
                x_reg <= x_reg + (y_reg >>> i_reg);
                y_reg <= y_reg - (x_reg >>> i_reg);
                z_reg <= z_reg + atan_q30(i_reg);
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
endmodule

// ----- tb/tb_planar_odometry_integrator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_odometry_integrator_core
// Self-checking bench for the odometry integrator. Command and tick beats go
// in through a bursty sender; pose beats come out through a stalling
// receiver. A local pose integrator predicts every tick and each pose beat
// is compared field by field with the oldest prediction. Gain and step are
// swept through several settings, extremes included, between phases.
// ----------------------------------------------------------------------------
module tb_planar_odometry_integrator_core;
    import poi_pkg::*;

    localparam int CycleLimit = 4000000;
    localparam int TickLatency = 200;
    localparam int RandItems = 1800;

    typedef struct {
        logic [0:0]         op;
        logic signed [15:0] tl;
        logic signed [15:0] ta;
        logic               known;
        out_item_t          pose;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    poi_in_if  in_ch ();
    poi_out_if out_ch ();

    planar_odometry_integrator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [15:0] gain_r;
    logic [15:0] step_r;
    logic signed [15:0] goal_lin_r, goal_ang_r, cur_lin_r, cur_ang_r, yaw_r;
    logic signed [31:0] px_r, py_r;

    out_item_t pose_q[$];
    int errors;
    int cycles;
    int stall_mode;
    logic stall_en;

    stim_row_t rows[$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_sh(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] ease(logic signed [15:0] cur,
                                                logic signed [15:0] goal);
        longint prod;
        prod = longint'(gain_r) * (longint'(goal) - longint'(cur));
        return clamp16(longint'(cur) + round_sh(prod, 16));
    endfunction

    function automatic longint atan_tab(int i);
        longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149,
                            1048576, 524288, 262144, 131072, 65536, 32768,
                            16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        return tab[i];
    endfunction

    // rotation CORDIC, results in units of 2^-30
    task automatic rotate(input logic signed [15:0] hd, output longint c,
                          output longint s);
        longint z, x, y, xs, ys, t;
        bit flip;
        z = longint'(hd) * 131072;
        x = longint'(K_Q30);
        y = 0;
        flip = 0;
        t = 0;
        if (z > longint'(HALF_PI_Q30))
        begin
            z -= longint'(PI_Q30);
            flip = 1;
        end
        else if (z < -longint'(HALF_PI_Q30))
        begin
            z += longint'(PI_Q30);
            flip = 1;
        end
        for (int i = 0; i < CordicStages && i < 24; i++)
        begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            t = longint'(atan_tab(i));
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= t;
            end
            else
            begin
                x += ys;
                y -= xs;
                z += t;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // advance the predicted pose by one beat; returns 1 when a pose is due
    task automatic integrate_beat(input logic [0:0] op, input logic signed [15:0] tl,
                                  input logic signed [15:0] ta, output bit has,
                                  output out_item_t pose);
        longint c, s, dt, h;
        has = 0;
        pose = '0;
        if (op == OP_CMD)
        begin
            goal_lin_r = tl;
            goal_ang_r = ta;
            return;
        end
        cur_lin_r = ease(cur_lin_r, goal_lin_r);
        cur_ang_r = ease(cur_ang_r, goal_ang_r);
        dt = longint'(step_r);
        rotate(yaw_r, c, s);
        // products can exceed 64 bits only in theory; v*c < 2^45, *dt < 2^61
        px_r = clamp32(longint'(px_r) + round_sh(longint'(cur_lin_r) * c * dt, 42));
        py_r = clamp32(longint'(py_r) + round_sh(longint'(cur_lin_r) * s * dt, 42));
        h = longint'(yaw_r) + round_sh(longint'(cur_ang_r) * dt, 15);
        while (h > longint'(PI_Q13)) h -= longint'(TWO_PI_Q13);
        while (h < -longint'(PI_Q13)) h += longint'(TWO_PI_Q13);
        yaw_r = h[15:0];
        has = 1;
        pose.pos_x = px_r;
        pose.pos_y = py_r;
        pose.heading = yaw_r;
        pose.lin_speed = cur_lin_r;
        pose.ang_speed = cur_ang_r;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // receiver: stall pattern of its own, check each pose beat
    initial
    begin
        out_item_t want;
        int phase;
        phase = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pose_q.size() == 0)
                    report("unexpected pose beat", 0, 0);
                else
                begin
                    want = pose_q.pop_front();
                    if (out_ch.data.pos_x !== want.pos_x)
                        report("pos_x", out_ch.data.pos_x, want.pos_x);
                    if (out_ch.data.pos_y !== want.pos_y)
                        report("pos_y", out_ch.data.pos_y, want.pos_y);
                    if (out_ch.data.heading !== want.heading)
                        report("heading", out_ch.data.heading, want.heading);
                    if (out_ch.data.lin_speed !== want.lin_speed)
                        report("lin_speed", out_ch.data.lin_speed, want.lin_speed);
                    if (out_ch.data.ang_speed !== want.ang_speed)
                        report("ang_speed", out_ch.data.ang_speed, want.ang_speed);
                end
            end
            phase++;
            if (!stall_en)
                out_ch.ready <= 1'b1;
            else if (stall_mode == 0)
                out_ch.ready <= ((phase % 7) < 4);
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // send one beat, feeding the predictor on acceptance
    task automatic send_beat(input logic [0:0] op, input logic signed [15:0] tl,
                             input logic signed [15:0] ta);
        bit has;
        out_item_t pose;
        in_ch.valid <= 1'b1;
        in_ch.data <= '{op: op, target_linear: tl, target_angular: ta};
        do @(posedge clk); while (!in_ch.ready);
        integrate_beat(op, tl, ta, has, pose);
        if (has) pose_q.push_back(pose);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        go_idle();
        @(posedge clk);
        while (pose_q.size() != 0) @(posedge clk);
        repeat (TickLatency) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GAIN) gain_r = val;
        else step_r = val;
    endtask

    function automatic logic signed [15:0] rand_speed();
        case ($urandom_range(0, 4))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    // random phase: bursts of beats, mostly ticks after each command
    task automatic random_phase(input int n);
        int left, burst;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_beat(OP_CMD, rand_speed(), rand_speed());
                else
                    send_beat(OP_TICK, 16'($urandom()), 16'($urandom()));
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                go_idle();
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    task automatic add_row(input logic [0:0] op, input logic signed [15:0] tl,
                           input logic signed [15:0] ta, input logic known,
                           input out_item_t pose);
        stim_row_t r;
        r.op = op;
        r.tl = tl;
        r.ta = ta;
        r.known = known;
        r.pose = pose;
        rows.push_back(r);
    endtask

    // stimulus
    initial
    begin
        logic [15:0] gains[4] = '{16'd0, 16'd65535, 16'd1, 16'd32768};
        logic [15:0] steps[4] = '{16'd65535, 16'd1, 16'd655, 16'd0};
        errors = 0;
        stall_en = 1'b0;
        stall_mode = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GAIN;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        gain_r = 16'd6554;
        step_r = 16'd655;
        goal_lin_r = '0;
        goal_ang_r = '0;
        cur_lin_r = '0;
        cur_ang_r = '0;
        yaw_r = '0;
        px_r = '0;
        py_r = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a tick straight after reset gives the zero pose
        add_row(OP_TICK, 16'sh7fff, -16'sh8000, 1'b1, '0);
        add_row(OP_CMD, 16'sh7fff, 16'sh7fff, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, '0);
        add_row(OP_CMD, -16'sh8000, -16'sh8000, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, '0);
        add_row(OP_TICK, '0, '0, 1'b0, '0);
        add_row(OP_CMD, '0, '0, 1'b0, '0);
        add_row(OP_TICK, -16'sd1, -16'sd1, 1'b0, '0);
        foreach (rows[i])
        begin
            send_beat(rows[i].op, rows[i].tl, rows[i].ta);
            if (rows[i].known)
            begin
                if (pose_q.size() != 0 && pose_q[$] != rows[i].pose)
                    report("directed pose after reset", 0, 0);
            end
        end
        drain();

        // full gain and large step: heading wraps, position runs toward the limits
        write_reg(REG_GAIN, 16'd65535);
        write_reg(REG_DT, 16'd65535);
        send_beat(OP_CMD, 16'sh7fff, 16'sh7fff);
        repeat (20) send_beat(OP_TICK, '0, '0);
        send_beat(OP_CMD, 16'sh7fff, -16'sh8000);
        repeat (20) send_beat(OP_TICK, '0, '0);
        // zero step: speeds smooth, pose stays put
        drain();
        write_reg(REG_DT, 16'd0);
        send_beat(OP_CMD, -16'sh8000, 16'sh1000);
        repeat (3) send_beat(OP_TICK, '0, '0);
        drain();

        // random phases across settings, extremes among them
        stall_en = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_GAIN, gains[p]);
            write_reg(REG_DT, steps[p]);
            stall_mode = p % 2;
            random_phase(RandItems / 8);
            drain();
            write_reg(REG_GAIN, 16'($urandom()));
            write_reg(REG_DT, 16'($urandom()));
            random_phase(RandItems / 8);
            drain();
        end

        // long run at full gain and step: ticks at top linear speed
        write_reg(REG_GAIN, 16'd65535);
        write_reg(REG_DT, 16'd65535);
        send_beat(OP_CMD, 16'sh7fff, 16'sh0);
        repeat (40) send_beat(OP_TICK, '0, '0);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
